/* src/tkz_pkg.sv */
// Shared types, token codes and character classes for the C subset tokenizer.
`default_nettype none

package tkz_pkg;

  localparam int unsigned ID_MAX_CHARS_DEF = 16;
  localparam int unsigned NUM_BITS_DEF     = 32;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TEXT_W  = 64;
  localparam int unsigned LINE_W  = 24;
  localparam int unsigned TEXT_CHARS = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned FCNT_W     = 3;

  // Token kinds
  localparam logic [KIND_W-1:0] TK_NUM    = 5'd0;
  localparam logic [KIND_W-1:0] TK_ID     = 5'd1;
  localparam logic [KIND_W-1:0] TK_TRUE   = 5'd2;
  localparam logic [KIND_W-1:0] TK_FALSE  = 5'd3;
  localparam logic [KIND_W-1:0] TK_RETURN = 5'd4;
  localparam logic [KIND_W-1:0] TK_INT    = 5'd5;
  localparam logic [KIND_W-1:0] TK_IF     = 5'd6;
  localparam logic [KIND_W-1:0] TK_ELSE   = 5'd7;
  localparam logic [KIND_W-1:0] TK_LPAREN = 5'd8;
  localparam logic [KIND_W-1:0] TK_RPAREN = 5'd9;
  localparam logic [KIND_W-1:0] TK_LBRACE = 5'd10;
  localparam logic [KIND_W-1:0] TK_RBRACE = 5'd11;
  localparam logic [KIND_W-1:0] TK_EQEQ   = 5'd12;
  localparam logic [KIND_W-1:0] TK_ASSIGN = 5'd13;
  localparam logic [KIND_W-1:0] TK_BAR    = 5'd14;
  localparam logic [KIND_W-1:0] TK_OROR   = 5'd15;
  localparam logic [KIND_W-1:0] TK_SEMI   = 5'd16;
  localparam logic [KIND_W-1:0] TK_PLUS   = 5'd17;
  localparam logic [KIND_W-1:0] TK_MINUS  = 5'd18;
  localparam logic [KIND_W-1:0] TK_STAR   = 5'd19;
  localparam logic [KIND_W-1:0] TK_COMMA  = 5'd20;
  localparam logic [KIND_W-1:0] TK_ERROR  = 5'd21;
  localparam logic [KIND_W-1:0] TK_END    = 5'd22;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  num;
    logic [CNT_W-1:0]  id_len;
    logic [TEXT_W-1:0] text_lo;
    logic [TEXT_W-1:0] text_hi;
    logic              trunc;
    logic [LINE_W-1:0] line;
    logic              last;
  } tkz_result_t;

  // What the scanner hands to the result queue in one cycle
  typedef struct packed {
    logic [1:0]  cnt;
    tkz_result_t r0;
    tkz_result_t r1;
  } tkz_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Single-character punctuators; TK_ERROR when the byte is not one
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      ";":     k = TK_SEMI;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      ",":     k = TK_COMMA;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // head holds the first six buffered characters, first one in the top byte
  function automatic logic [KIND_W-1:0] kw_kind(input logic [47:0] head,
                                                input logic [CNT_W-1:0] len);
    logic [KIND_W-1:0] k;
    k = TK_ID;
    if (len == CNT_W'(4) && head[47:16] == "true")        k = TK_TRUE;
    else if (len == CNT_W'(5) && head[47:8] == "false")   k = TK_FALSE;
    else if (len == CNT_W'(6) && head == "return")        k = TK_RETURN;
    else if (len == CNT_W'(3) && head[47:24] == "int")    k = TK_INT;
    else if (len == CNT_W'(2) && head[47:32] == "if")     k = TK_IF;
    else if (len == CNT_W'(4) && head[47:16] == "else")   k = TK_ELSE;
    return k;
  endfunction

  function automatic tkz_result_t plain_result(input logic [KIND_W-1:0] kind,
                                               input logic [NUM_W-1:0] num,
                                               input logic [LINE_W-1:0] line);
    tkz_result_t r;
    r         = '0;
    r.kind    = kind;
    r.num     = num;
    r.line    = line;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/c_subset_tokenizer_core.sv */
// Top level of the C subset tokenizer: input register, scanner, result queue.
//
// Input channel: one source byte (char_code_i) per request, or an end marker
// (end_of_input_i) that flushes the pending token, emits an end token and
// returns the scanner to its reset state. A request is taken on a clock edge
// with in_valid_i high and in_stall_o low.
// Output channel: one token per request on the out_* ports, taken on an edge
// with out_valid_o high and out_stall_i low. A byte yields zero, one or two
// tokens; last_of_run_o marks the final token of a byte.
// Each byte is held in the input register, then the scanner writes its tokens
// into the result queue, from which they are taken.
// Throughput: one byte per cycle; the output port delivers one token per
// cycle, so bytes that yield two tokens throttle input through the four-entry
// result queue. The scanner holds a byte while the queue lacks two free slots.
// Stall: a stalled result holds its payload; the input side stalls once the
// input register is full and the queue cannot take its results.
// Reset: queue emptied, scanner idle, line number back to one.
`default_nettype none

module c_subset_tokenizer_core
  import tkz_pkg::*;
#(
  parameter int unsigned ID_MAX_CHARS = ID_MAX_CHARS_DEF,
  parameter int unsigned NUM_BITS     = NUM_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              end_of_input_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [KIND_W-1:0]      token_kind_o,
  output logic [NUM_W-1:0]       number_value_o,
  output logic [CNT_W-1:0]       id_length_o,
  output logic [TEXT_W-1:0]      id_text_low_o,
  output logic [TEXT_W-1:0]      id_text_high_o,
  output logic                   id_truncated_o,
  output logic [LINE_W-1:0]      line_number_o,
  output logic                   last_of_run_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  char_q;
  logic        eoi_q;
  logic        accept;
  logic        proc;
  logic        pop;
  logic        room2;
  tkz_push_t   push;
  tkz_result_t head;

  assign proc       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept || (in_vld_q && !proc);
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
      eoi_q  <= end_of_input_i;
    end
  end

  tkz_scanner #(
    .ID_MAX_CHARS (ID_MAX_CHARS),
    .NUM_BITS     (NUM_BITS)
  ) u_scanner (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (proc),
    .char_code_i    (char_q),
    .end_of_input_i (eoi_q),
    .push_o         (push)
  );

  tkz_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (out_valid_o),
    .room2_o    (room2)
  );

  assign token_kind_o   = head.kind;
  assign number_value_o = head.num;
  assign id_length_o    = head.id_len;
  assign id_text_low_o  = head.text_lo;
  assign id_text_high_o = head.text_hi;
  assign id_truncated_o = head.trunc;
  assign line_number_o  = head.line;
  assign last_of_run_o  = head.last;

`ifndef NO_ASSERTIONS
  // an end marker always yields at least the end token
  a_eoi_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && eoi_q) |-> (push.cnt != 2'd0))
    else $error("end marker produced no token");

  // of a pair, only the second closes the run
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (push.r1.last && !push.r0.last))
    else $error("last flag misplaced in token pair");

  // nothing is pushed without a processed byte
  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> proc)
    else $error("token pushed without a byte");

  // the end token always closes its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == TK_END) |-> last_of_run_o)
    else $error("end token not marked last");
`endif

endmodule

`default_nettype wire

/* src/tkz_scanner.sv */
// Scanner state and per-byte token logic; emits up to two results per request.
`default_nettype none

module tkz_scanner
  import tkz_pkg::*;
#(
  parameter int unsigned ID_MAX_CHARS = ID_MAX_CHARS_DEF,
  parameter int unsigned NUM_BITS     = NUM_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_of_input_i,
  output tkz_push_t       push_o
);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_NUM  = 3'd1;
  localparam logic [2:0] MODE_ID   = 3'd2;
  localparam logic [2:0] MODE_EQ   = 3'd3;
  localparam logic [2:0] MODE_BAR  = 3'd4;

  logic [2:0]          mode_q, mode_d;
  logic [NUM_BITS-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]    id_cnt_q, id_cnt_d;
  logic                id_ovf_q, id_ovf_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic                err_q, err_d;
  logic [7:0]          id_buf_q [ID_MAX_CHARS];

  logic                buf_we;
  logic [CNT_W-1:0]    buf_sel;

  logic                use_pend;
  logic                own_v;
  logic [KIND_W-1:0]   own_kind;
  logic                pend_v;
  tkz_result_t         pend_res;
  tkz_result_t         own_res;
  logic [8*TEXT_CHARS-1:0] text;
  logic [47:0]         kw_head;
  logic [KIND_W-1:0]   kw;
  logic [NUM_BITS-1:0] acc_x10;
  logic [NUM_BITS-1:0] dig;
  logic                c_dig, c_alpha;

  assign c_dig   = is_digit(char_code_i);
  assign c_alpha = is_alpha(char_code_i);
  assign dig     = NUM_BITS'(char_code_i[3:0]);
  // x10 as x8 + x2
  assign acc_x10 = NUM_BITS'({acc_q, 3'b000}) + NUM_BITS'({acc_q, 1'b0}) + dig;

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    id_cnt_d = id_cnt_q;
    id_ovf_d = id_ovf_q;
    line_d   = line_q;
    err_d    = err_q;
    buf_we   = 1'b0;
    buf_sel  = id_cnt_q;
    use_pend = 1'b0;
    own_v    = 1'b0;
    own_kind = TK_END;
    if (end_of_input_i) begin
      use_pend = !err_q;
      own_v    = 1'b1;
      mode_d   = MODE_IDLE;
      acc_d    = '0;
      id_cnt_d = '0;
      id_ovf_d = 1'b0;
      line_d   = LINE_W'(1);
      err_d    = 1'b0;
    end else if (err_q) begin
      own_v = 1'b0;
    end else if (mode_q == MODE_NUM && c_dig) begin
      acc_d = acc_x10;
    end else if (mode_q == MODE_ID && (c_alpha || c_dig)) begin
      if (id_cnt_q < CNT_W'(ID_MAX_CHARS)) begin
        buf_we   = 1'b1;
        id_cnt_d = id_cnt_q + CNT_W'(1);
      end else begin
        id_ovf_d = 1'b1;
      end
    end else if (mode_q == MODE_EQ && char_code_i == CH_EQ) begin
      mode_d   = MODE_IDLE;
      own_v    = 1'b1;
      own_kind = TK_EQEQ;
    end else if (mode_q == MODE_BAR && char_code_i == CH_BAR) begin
      mode_d   = MODE_IDLE;
      own_v    = 1'b1;
      own_kind = TK_OROR;
    end else begin
      // flush whatever is pending, then start on this byte
      use_pend = 1'b1;
      mode_d   = MODE_IDLE;
      acc_d    = '0;
      id_cnt_d = '0;
      id_ovf_d = 1'b0;
      if (char_code_i == CH_NL) begin
        if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
      end else if (is_space(char_code_i)) begin
        own_v = 1'b0;
      end else if (c_dig) begin
        mode_d = MODE_NUM;
        acc_d  = dig;
      end else if (c_alpha) begin
        mode_d   = MODE_ID;
        buf_we   = 1'b1;
        buf_sel  = '0;
        id_cnt_d = CNT_W'(1);
      end else if (char_code_i == CH_EQ) begin
        mode_d = MODE_EQ;
      end else if (char_code_i == CH_BAR) begin
        mode_d = MODE_BAR;
      end else begin
        own_v    = 1'b1;
        own_kind = punct_kind(char_code_i);
        if (own_kind == TK_ERROR) err_d = 1'b1;
      end
    end
  end

  // identifier text, zero beyond the held count
  always_comb begin
    text = '0;
    for (int i = 0; i < ID_MAX_CHARS; i++) begin
      if (CNT_W'(i) < id_cnt_q) text[8*i +: 8] = id_buf_q[i];
    end
  end

  assign kw_head = {id_buf_q[0], id_buf_q[1], id_buf_q[2],
                    id_buf_q[3], id_buf_q[4], id_buf_q[5]};
  assign kw      = kw_kind(kw_head, id_cnt_q);

  always_comb begin
    pend_v   = use_pend;
    pend_res = plain_result(TK_NUM, '0, line_q);
    case (mode_q)
      MODE_NUM: pend_res = plain_result(TK_NUM, NUM_W'(acc_q), line_q);
      MODE_ID: begin
        if (!id_ovf_q && kw != TK_ID) begin
          pend_res = plain_result(kw, '0, line_q);
        end else begin
          pend_res         = plain_result(TK_ID, '0, line_q);
          pend_res.id_len  = id_cnt_q;
          pend_res.text_lo = text[TEXT_W-1:0];
          pend_res.text_hi = text[2*TEXT_W-1:TEXT_W];
          pend_res.trunc   = id_ovf_q;
        end
      end
      MODE_EQ:  pend_res = plain_result(TK_ASSIGN, '0, line_q);
      MODE_BAR: pend_res = plain_result(TK_BAR, '0, line_q);
      default:  pend_v   = 1'b0;
    endcase
    own_res      = plain_result(own_kind, '0, line_q);
    own_res.last = 1'b1;
  end

  always_comb begin
    push_o    = '0;
    push_o.r0 = own_res;
    push_o.r1 = own_res;
    if (step_i) begin
      if (pend_v && own_v) begin
        push_o.cnt = 2'd2;
        push_o.r0  = pend_res;
      end else if (pend_v) begin
        push_o.cnt     = 2'd1;
        push_o.r0      = pend_res;
        push_o.r0.last = 1'b1;
      end else if (own_v) begin
        push_o.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      acc_q    <= '0;
      id_cnt_q <= '0;
      id_ovf_q <= 1'b0;
      line_q   <= LINE_W'(1);
      err_q    <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      id_cnt_q <= id_cnt_d;
      id_ovf_q <= id_ovf_d;
      line_q   <= line_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ID_MAX_CHARS; i++) begin
      if (step_i && buf_we && buf_sel == CNT_W'(i)) id_buf_q[i] <= char_code_i;
    end
  end

endmodule

`default_nettype wire

/* src/tkz_result_fifo.sv */
// Four-entry result queue; takes up to two results a cycle, gives one.
`default_nettype none

module tkz_result_fifo
  import tkz_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tkz_push_t push_i,
  input  wire logic      pop_i,
  output tkz_result_t    head_o,
  output logic           nonempty_o,
  output logic           room2_o
);

  tkz_result_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [FCNT_W-1:0]  cnt_q;

  assign head_o     = mem_q[rd_q];
  assign nonempty_o = cnt_q != '0;
  // room for two more after this cycle's pop
  assign room2_o    = (cnt_q - FCNT_W'(pop_i)) <= FCNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.cnt);
      rd_q  <= rd_q + PTR_W'(pop_i);
      cnt_q <= cnt_q + FCNT_W'(push_i.cnt) - FCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_q + PTR_W'(1)] <= push_i.r1;
  end

endmodule

`default_nettype wire

/* tb/tb_c_subset_tokenizer_core.sv */
// Self-checking testbench for the C subset tokenizer core.
`timescale 1ns / 100ps

module tb_c_subset_tokenizer_core;
  import tkz_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned WORD_MAX    = ID_MAX_CHARS_DEF;
  localparam int unsigned RAND_ITEMS  = 500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 20;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic [7:0]        char_code_i    = '0;
  logic              end_of_input_i = 1'b0;
  logic              out_stall_i    = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [KIND_W-1:0] token_kind_o;
  logic [NUM_W-1:0]  number_value_o;
  logic [CNT_W-1:0]  id_length_o;
  logic [TEXT_W-1:0] id_text_low_o;
  logic [TEXT_W-1:0] id_text_high_o;
  logic              id_truncated_o;
  logic [LINE_W-1:0] line_number_o;
  logic              last_of_run_o;

  c_subset_tokenizer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .number_value_o (number_value_o),
    .id_length_o    (id_length_o),
    .id_text_low_o  (id_text_low_o),
    .id_text_high_o (id_text_high_o),
    .id_truncated_o (id_truncated_o),
    .line_number_o  (line_number_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  // One input request; kind and line are the typed-in expectation when typed is set
  typedef struct packed {
    logic [7:0]        c;
    logic              e;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
  } stim_row_t;

  typedef enum logic [2:0] {LX_IDLE, LX_NUM, LX_WORD, LX_EQ, LX_BAR} lex_state_e;

  // Scanner state as predicted
  lex_state_e        lx_state;
  logic [NUM_W-1:0]  lx_value;
  logic [7:0]        lx_word [WORD_MAX];
  int unsigned       lx_len;
  bit                lx_cut;
  logic [LINE_W-1:0] lx_line;
  bit                lx_dead;
  int unsigned       run_n;

  tkz_result_t tok_q [$];
  stim_row_t   src_q [$];

  string             kw_names [6] = '{"true", "false", "return", "int", "if", "else"};
  logic [KIND_W-1:0] kw_kinds [6] = '{TK_TRUE, TK_FALSE, TK_RETURN, TK_INT, TK_IF, TK_ELSE};
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string punct_set = "(){}=|;+-*,";

  int unsigned n_fail, n_bytes, n_useful, n_tokens, n_pairs, n_ends;
  int unsigned cycle_cnt;
  bit          send_burst, recv_burst, hold_req, hold_fired, pause_done;

  // Directed part: typed rows expect exactly one plain token
  stim_row_t dir_rows [25] = '{
    '{"(",      1'b0, 1'b1, TK_LPAREN, 24'd1},
    '{"=",      1'b0, 1'b0, '0,        '0},
    '{"=",      1'b0, 1'b0, '0,        '0},
    '{"|",      1'b0, 1'b0, '0,        '0},
    '{" ",      1'b0, 1'b0, '0,        '0},
    '{"|",      1'b0, 1'b0, '0,        '0},
    '{"|",      1'b0, 1'b0, '0,        '0},
    '{"i",      1'b0, 1'b0, '0,        '0},
    '{"f",      1'b0, 1'b0, '0,        '0},
    '{CH_NL,    1'b0, 1'b0, '0,        '0},
    '{"9",      1'b0, 1'b0, '0,        '0},
    '{"9",      1'b0, 1'b0, '0,        '0},
    '{"=",      1'b0, 1'b0, '0,        '0},
    '{"z",      1'b0, 1'b0, '0,        '0},
    '{";",      1'b0, 1'b0, '0,        '0},
    '{"_",      1'b0, 1'b0, '0,        '0},
    '{8'h00,    1'b1, 1'b0, '0,        '0},
    '{")",      1'b0, 1'b1, TK_RPAREN, 24'd1},
    '{8'hFF,    1'b0, 1'b1, TK_ERROR,  24'd1},
    '{CH_NL,    1'b0, 1'b0, '0,        '0},
    '{"+",      1'b0, 1'b0, '0,        '0},
    '{8'h7F,    1'b1, 1'b1, TK_END,    24'd1},
    '{8'h00,    1'b0, 1'b1, TK_ERROR,  24'd1},
    '{8'hFF,    1'b1, 1'b1, TK_END,    24'd1},
    '{8'hA5,    1'b1, 1'b1, TK_END,    24'd1}
  };

  function automatic bit chr_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit chr_letter(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic bit chr_blank(logic [7:0] c);
    return c == CH_SPACE || c inside {[CH_TAB:CH_CR]};
  endfunction

  function automatic bit chr_known(logic [7:0] c);
    return chr_digit(c) || chr_letter(c) || chr_blank(c) ||
           c inside {"(", ")", "{", "}", "=", "|", ";", "+", "-", "*", ","};
  endfunction

  function automatic void lex_reset();
    lx_state = LX_IDLE;
    lx_value = '0;
    lx_len   = 0;
    lx_cut   = 1'b0;
    lx_line  = LINE_W'(1);
    lx_dead  = 1'b0;
  endfunction

  function automatic void push_tok(logic [KIND_W-1:0] k, logic [NUM_W-1:0] v, bit with_word);
    tkz_result_t r;
    r      = '0;
    r.kind = k;
    r.num  = v;
    r.line = lx_line;
    if (with_word) begin
      r.id_len = CNT_W'(lx_len);
      r.trunc  = lx_cut;
      for (int i = 0; i < lx_len; i++) begin
        if (i < 8) r.text_lo[8*i +: 8] = lx_word[i];
        else       r.text_hi[8*(i-8) +: 8] = lx_word[i];
      end
    end
    tok_q.push_back(r);
    run_n++;
  endfunction

  // Emit whatever token is pending and return to idle
  function automatic void close_token();
    bit hit;
    hit = 1'b0;
    case (lx_state)
      LX_NUM: push_tok(TK_NUM, lx_value, 1'b0);
      LX_WORD: begin
        // a cut identifier is never a keyword
        for (int k = 0; k < 6 && !lx_cut && !hit; k++) begin
          if (kw_names[k].len() == lx_len) begin
            hit = 1'b1;
            for (int i = 0; i < lx_len; i++)
              if (kw_names[k][i] != lx_word[i]) hit = 1'b0;
            if (hit) push_tok(kw_kinds[k], '0, 1'b0);
          end
        end
        if (!hit) push_tok(TK_ID, '0, 1'b1);
      end
      LX_EQ:  push_tok(TK_ASSIGN, '0, 1'b0);
      LX_BAR: push_tok(TK_BAR, '0, 1'b0);
      default: ;
    endcase
    lx_state = LX_IDLE;
    lx_value = '0;
    lx_len   = 0;
    lx_cut   = 1'b0;
  endfunction

  function automatic void open_token(logic [7:0] c);
    if (c == CH_NL) begin
      if (lx_line != LINE_MAX) lx_line++;
    end else if (chr_blank(c)) begin
    end else if (chr_digit(c)) begin
      lx_state = LX_NUM;
      lx_value = NUM_W'(c - "0");
    end else if (chr_letter(c)) begin
      lx_state   = LX_WORD;
      lx_word[0] = c;
      lx_len     = 1;
    end else begin
      case (c)
        "=": lx_state = LX_EQ;
        "|": lx_state = LX_BAR;
        "(": push_tok(TK_LPAREN, '0, 1'b0);
        ")": push_tok(TK_RPAREN, '0, 1'b0);
        "{": push_tok(TK_LBRACE, '0, 1'b0);
        "}": push_tok(TK_RBRACE, '0, 1'b0);
        ";": push_tok(TK_SEMI, '0, 1'b0);
        "+": push_tok(TK_PLUS, '0, 1'b0);
        "-": push_tok(TK_MINUS, '0, 1'b0);
        "*": push_tok(TK_STAR, '0, 1'b0);
        ",": push_tok(TK_COMMA, '0, 1'b0);
        default: begin
          push_tok(TK_ERROR, '0, 1'b0);
          lx_dead = 1'b1;
        end
      endcase
    end
  endfunction

  // Queue the tokens one accepted request causes; returns 1 if it was ignored
  function automatic bit predict_byte(logic [7:0] c, logic e);
    bit ignored;
    tkz_result_t r;
    ignored = lx_dead && !e;
    run_n   = 0;
    if (e) begin
      if (!lx_dead) close_token();
      push_tok(TK_END, '0, 1'b0);
      lex_reset();
      n_ends++;
    end else if (lx_dead) begin
    end else if (lx_state == LX_NUM && chr_digit(c)) begin
      lx_value = lx_value * NUM_W'(10) + NUM_W'(c - "0");
    end else if (lx_state == LX_WORD && (chr_letter(c) || chr_digit(c))) begin
      if (lx_len < WORD_MAX) begin
        lx_word[lx_len] = c;
        lx_len++;
      end else begin
        lx_cut = 1'b1;
      end
    end else if (lx_state == LX_EQ && c == CH_EQ) begin
      lx_state = LX_IDLE;
      push_tok(TK_EQEQ, '0, 1'b0);
    end else if (lx_state == LX_BAR && c == CH_BAR) begin
      lx_state = LX_IDLE;
      push_tok(TK_OROR, '0, 1'b0);
    end else begin
      close_token();
      open_token(c);
    end
    if (run_n != 0) begin
      r      = tok_q.pop_back();
      r.last = 1'b1;
      tok_q.push_back(r);
    end
    if (run_n == 2) n_pairs++;
    return ignored;
  endfunction

  function automatic void add_byte(logic [7:0] c, logic e);
    stim_row_t row;
    row   = '0;
    row.c = c;
    row.e = e;
    src_q.push_back(row);
  endfunction

  // One random lexeme; mostly well formed, some broken input and end markers
  function automatic void gen_lexeme();
    int unsigned sel, n, k;
    logic [7:0]  b;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (n) add_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    end else if (sel < 44) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, 5);
        for (int i = 0; i < kw_names[k].len(); i++) add_byte(kw_names[k][i], 1'b0);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        add_byte(alpha_set[$urandom_range(0, alpha_set.len() - 1)], 1'b0);
        repeat (n - 1) add_byte(alnum_set[$urandom_range(0, alnum_set.len() - 1)], 1'b0);
      end
    end else if (sel < 64) begin
      add_byte(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
    end else if (sel < 68) begin
      b = $urandom_range(0, 1) ? CH_EQ : CH_BAR;
      add_byte(b, 1'b0);
      add_byte(b, 1'b0);
    end else if (sel < 88) begin
      n = $urandom_range(0, 9);
      if (n < 3)      add_byte(CH_NL, 1'b0);
      else if (n < 7) add_byte(CH_SPACE, 1'b0);
      else            add_byte(8'(CH_TAB + $urandom_range(0, 4)), 1'b0);
    end else if (sel < 92) begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      if (sel < 95) begin
        do b = 8'($urandom_range(0, 255)); while (chr_known(b));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      add_byte(b, 1'b0);
      // an unknown byte kills the input until the next end marker, so keep that stretch short
      if (!chr_known(b)) begin
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s: got %0h, want %0h", n_tokens, name, got, want));
  endtask

  task automatic check_token();
    tkz_result_t want;
    n_tokens++;
    if (tok_q.size() == 0) begin
      report_mismatch($sformatf("token %0d of kind %0d with nothing expected",
                                n_tokens, token_kind_o));
      return;
    end
    want = tok_q.pop_front();
    cmp_field("token_kind", 64'(token_kind_o), 64'(want.kind));
    cmp_field("number_value", 64'(number_value_o), 64'(want.num));
    cmp_field("id_length", 64'(id_length_o), 64'(want.id_len));
    cmp_field("id_text_low", id_text_low_o, want.text_lo);
    cmp_field("id_text_high", id_text_high_o, want.text_hi);
    cmp_field("id_truncated", 64'(id_truncated_o), 64'(want.trunc));
    cmp_field("line_number", 64'(line_number_o), 64'(want.line));
    cmp_field("last_of_run", 64'(last_of_run_o), 64'(want.last));
  endtask

  task automatic send_byte(input stim_row_t row);
    int unsigned gap;
    tkz_result_t fixed;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= row.c;
    end_of_input_i <= row.e;
    do @(posedge clk_i); while (in_stall_o);
    n_bytes++;
    if (!predict_byte(row.c, row.e)) n_useful++;
    if (row.typed) begin
      fixed      = '0;
      fixed.kind = row.kind;
      fixed.line = row.line;
      fixed.last = 1'b1;
      if (run_n != 1 || tok_q[tok_q.size() - 1] !== fixed)
        report_mismatch($sformatf("directed byte %0h: table and predictor disagree", row.c));
      if (run_n != 0) void'(tok_q.pop_back());
      tok_q.push_back(fixed);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls per token, plus one long hold on request
  initial begin : sink
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        check_token();
        stall_left = recv_burst ? 0 : $urandom_range(0, 17);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (stall_left != 0) || (hold_left != 0);
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int unsigned n_directed;
    n_fail    = 0;
    n_bytes   = 0;
    n_useful  = 0;
    n_tokens  = 0;
    n_pairs   = 0;
    n_ends    = 0;
    lex_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i]);
    n_directed = n_bytes;
    n_useful   = 0;

    while (n_useful < RAND_ITEMS) begin
      if (src_q.size() == 0) gen_lexeme();
      row        = src_q.pop_front();
      // back-to-back stretches; the second one runs into the long output hold
      send_burst = (n_useful >= 120 && n_useful < 200) || (n_useful >= 250 && n_useful < 290);
      recv_burst = (n_useful >= 120 && n_useful < 200);
      if (n_useful == 250 && !hold_fired) begin
        hold_fired = 1'b1;
        hold_req   = 1'b1;
      end
      if (n_useful == 400 && !pause_done) begin
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (tok_q.size() != 0) @(posedge clk_i);
      end
      send_byte(row);
    end
    in_valid_i <= 1'b0;

    while (tok_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run: %0d requests (%0d directed), %0d tokens checked, %0d requests with two tokens",
             n_bytes, n_directed, n_tokens, n_pairs);
    $display("Run: %0d end markers, a %0d-cycle output hold and one full drain pause",
             n_ends, HOLD_CYCLES);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
